[rtl/bk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bk_pkg
// Shared constants, codes and types of the deadlock-avoidance block.
// ----------------------------------------------------------------------------
package bk_pkg;

	localparam int DEF_NUM_PROCS = 5;
	localparam int DEF_NUM_RES   = 3;
	localparam int DEF_UNIT_BITS = 8;

	localparam int MAX_RES  = 3;
	localparam int AMT_W    = 8;
	localparam int PROC_W   = 4;
	localparam int STATUS_W = 3;

	typedef enum logic [1:0] {
		OP_FREE    = 2'd0,
		OP_LOAD    = 2'd1,
		OP_REQUEST = 2'd2,
		OP_CHECK   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_CLAIM     = 3'd1,
		ST_WAIT      = 3'd2,
		ST_UNSAFE    = 3'd3,
		ST_BAD_LOAD  = 3'd4,
		ST_BAD_INDEX = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_INIT,
		S_SCAN,
		S_RESP,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic fits;
		logic over_claim;
		logic over_free;
		logic bad_load;
	} lane_flag_t;

	typedef struct packed {
		logic    all_fit;
		logic    load_bad;
		logic    req_fail;
		status_t req_code;
	} merge_t;

endpackage

[rtl/bk_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bk_lane
// One resource lane: claim and availability compares, working-vector sum
// and the remaining claim of a row load.
// ----------------------------------------------------------------------------
module bk_lane import bk_pkg::*; #(
	parameter int UNIT_BITS = DEF_UNIT_BITS,
	parameter int WORK_BITS = DEF_UNIT_BITS + 3
) (
	input  logic [UNIT_BITS-1:0] claim,
	input  logic [UNIT_BITS-1:0] held,
	input  logic [WORK_BITS-1:0] work,
	input  logic [UNIT_BITS-1:0] amount,
	input  logic [UNIT_BITS-1:0] load_held,
	input  logic [UNIT_BITS-1:0] free,
	output lane_flag_t           flags,
	output logic [WORK_BITS-1:0] work_sum,
	output logic [UNIT_BITS-1:0] load_claim
);

	always_comb begin
		flags.fits       = WORK_BITS'(claim) <= work;
		flags.over_claim = amount > claim;
		flags.over_free  = amount > free;
		flags.bad_load   = amount < load_held;
	end

	assign work_sum   = work + WORK_BITS'(held);
	assign load_claim = amount - load_held;

endmodule

[rtl/bk_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bk_merge
// Combines the lane flags: whole-row fit, bad load, and the first failing
// request check in resource order, claim before availability.
// ----------------------------------------------------------------------------
module bk_merge import bk_pkg::*; #(
	parameter int NUM_RES = DEF_NUM_RES
) (
	input  lane_flag_t [NUM_RES-1:0] flags,
	output merge_t                   merged
);

	always_comb begin
		merged.all_fit  = 1'b1;
		merged.load_bad = 1'b0;
		merged.req_fail = 1'b0;
		merged.req_code = ST_OK;
		for (int j = NUM_RES - 1; j >= 0; j--) begin
			merged.all_fit  = merged.all_fit & flags[j].fits;
			merged.load_bad = merged.load_bad | flags[j].bad_load;
			if (flags[j].over_free) begin
				merged.req_fail = 1'b1;
				merged.req_code = ST_WAIT;
			end
			if (flags[j].over_claim) begin
				merged.req_fail = 1'b1;
				merged.req_code = ST_CLAIM;
			end
		end
	end

endmodule

[rtl/bankers_safety_and_request.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_safety_and_request
// Resource bookkeeping with request checks and a row-serial safety check
// whose resource compares run in parallel lanes.
//
//   Channel  Direction  Handshake            Word
//   in       input      in_valid / in_stall  op, process, amount_0..2, held_0..2
//   out      output     out_valid/out_stall  status, seq_process, seq_position, last
//
// Set free units and row loads pass through the execute and response states
// before the result word is registered. A safety check scans one process row
// per cycle; a safe check then emits one word per cycle unless the output
// stalls. A new word is accepted only once the previous one is finished.
// Reset clears all units, claims and the control state.
// A stalled output holds the finished word while the next word is accepted.
// ----------------------------------------------------------------------------
module bankers_safety_and_request import bk_pkg::*; #(
	parameter int NUM_PROCS = DEF_NUM_PROCS,
	parameter int NUM_RES   = DEF_NUM_RES,
	parameter int UNIT_BITS = DEF_UNIT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [PROC_W-1:0]   process,
	input  logic [AMT_W-1:0]    amount_0,
	input  logic [AMT_W-1:0]    amount_1,
	input  logic [AMT_W-1:0]    amount_2,
	input  logic [AMT_W-1:0]    held_0,
	input  logic [AMT_W-1:0]    held_1,
	input  logic [AMT_W-1:0]    held_2,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [PROC_W-1:0]   seq_process,
	output logic [PROC_W-1:0]   seq_position,
	output logic                last
);

	localparam int PIDX_W    = $clog2(NUM_PROCS);
	localparam int CNT_W     = $clog2(NUM_PROCS + 1);
	localparam int WORK_BITS = UNIT_BITS + CNT_W;
	localparam logic [PIDX_W-1:0] LAST_IDX = PIDX_W'(NUM_PROCS - 1);

	state_t state_q, state_n;

	logic [AMT_W-1:0]     amt_raw [MAX_RES];
	logic [AMT_W-1:0]     hld_raw [MAX_RES];

	op_t                  op_q;
	logic [PROC_W-1:0]    proc_q;
	logic [UNIT_BITS-1:0] amt_q [NUM_RES];
	logic [UNIT_BITS-1:0] hld_q [NUM_RES];

	logic [UNIT_BITS-1:0] free_q  [NUM_RES];
	logic [UNIT_BITS-1:0] held_q  [NUM_PROCS][NUM_RES];
	logic [UNIT_BITS-1:0] claim_q [NUM_PROCS][NUM_RES];
	logic [WORK_BITS-1:0] work_q  [NUM_RES];
	logic [NUM_PROCS-1:0] fin_q;
	logic [PIDX_W-1:0]    order_q [NUM_PROCS];
	logic [CNT_W-1:0]     count_q;
	logic [PIDX_W-1:0]    idx_q;
	logic [PIDX_W-1:0]    pos_q;
	logic                 progress_q;

	logic [STATUS_W-1:0]  res_q, res_n;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [PROC_W-1:0]    seq_proc_q;
	logic [PROC_W-1:0]    seq_pos_q;
	logic                 last_q;

	logic [PIDX_W-1:0]    row;
	logic [PIDX_W-1:0]    prow;
	lane_flag_t [NUM_RES-1:0] flags;
	logic [WORK_BITS-1:0] work_sum   [NUM_RES];
	logic [UNIT_BITS-1:0] load_claim [NUM_RES];
	merge_t               merged;

	logic accept, out_free, bad_idx, take;
	logic free_wr, load_wr, alloc, rollback, scan_init, scan_step, push, emit;

	assign amt_raw[0] = amount_0;
	assign amt_raw[1] = amount_1;
	assign amt_raw[2] = amount_2;
	assign hld_raw[0] = held_0;
	assign hld_raw[1] = held_1;
	assign hld_raw[2] = held_2;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;
	assign bad_idx  = {1'b0, proc_q} >= (PROC_W + 1)'(NUM_PROCS);
	assign prow     = proc_q[PIDX_W-1:0];
	assign row      = (state_q == S_SCAN) ? idx_q : prow;
	assign take     = ~fin_q[idx_q] & merged.all_fit;

	for (genvar j = 0; j < NUM_RES; j++) begin : g_lane
		bk_lane #(
			.UNIT_BITS (UNIT_BITS),
			.WORK_BITS (WORK_BITS)
		) u_lane (
			.claim      (claim_q[row][j]),
			.held       (held_q[row][j]),
			.work       (work_q[j]),
			.amount     (amt_q[j]),
			.load_held  (hld_q[j]),
			.free       (free_q[j]),
			.flags      (flags[j]),
			.work_sum   (work_sum[j]),
			.load_claim (load_claim[j])
		);
	end

	bk_merge #(
		.NUM_RES (NUM_RES)
	) u_merge (
		.flags  (flags),
		.merged (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		res_n     = res_q;
		free_wr   = 1'b0;
		load_wr   = 1'b0;
		alloc     = 1'b0;
		rollback  = 1'b0;
		scan_init = 1'b0;
		scan_step = 1'b0;
		push      = 1'b0;
		emit      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_FREE: begin
						free_wr = 1'b1;
						res_n   = ST_OK;
						state_n = S_RESP;
					end
					OP_CHECK: begin
						state_n = S_INIT;
					end
					default: begin
						if (bad_idx) begin
							res_n   = ST_BAD_INDEX;
							state_n = S_RESP;
						end else if (op_q == OP_LOAD) begin
							load_wr = 1'b1;
							res_n   = merged.load_bad ? ST_BAD_LOAD : ST_OK;
							state_n = S_RESP;
						end else if (merged.req_fail) begin
							res_n   = merged.req_code;
							state_n = S_RESP;
						end else begin
							alloc   = 1'b1;
							state_n = S_INIT;
						end
					end
				endcase
			end
			S_INIT: begin
				scan_init = 1'b1;
				state_n   = S_SCAN;
			end
			S_SCAN: begin
				scan_step = 1'b1;
				if (take && count_q == CNT_W'(NUM_PROCS - 1)) begin
					if (op_q == OP_CHECK) begin
						state_n = S_EMIT;
					end else begin
						res_n   = ST_OK;
						state_n = S_RESP;
					end
				end else if (idx_q == LAST_IDX && !progress_q && !take) begin
					res_n    = ST_UNSAFE;
					rollback = (op_q == OP_REQUEST);
					state_n  = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					push    = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					push = 1'b1;
					emit = 1'b1;
					if (pos_q == LAST_IDX) begin
						state_n = S_IDLE;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(op);
			proc_q <= process;
			for (int j = 0; j < NUM_RES; j++) begin
				amt_q[j] <= UNIT_BITS'(amt_raw[j]);
				hld_q[j] <= UNIT_BITS'(hld_raw[j]);
			end
		end
		if (scan_step && take) begin
			order_q[count_q[PIDX_W-1:0]] <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_RES; j++) begin
				free_q[j] <= '0;
				work_q[j] <= '0;
			end
			for (int i = 0; i < NUM_PROCS; i++) begin
				for (int j = 0; j < NUM_RES; j++) begin
					held_q[i][j]  <= '0;
					claim_q[i][j] <= '0;
				end
			end
			fin_q      <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			pos_q      <= '0;
			progress_q <= 1'b0;
			res_q      <= ST_OK;
		end else begin
			res_q <= res_n;
			for (int j = 0; j < NUM_RES; j++) begin
				if (free_wr) begin
					free_q[j] <= amt_q[j];
				end
				if (load_wr) begin
					held_q[prow][j]  <= hld_q[j];
					claim_q[prow][j] <= merged.load_bad ? '0 : load_claim[j];
				end
				if (alloc) begin
					free_q[j]        <= free_q[j] - amt_q[j];
					held_q[prow][j]  <= held_q[prow][j] + amt_q[j];
					claim_q[prow][j] <= claim_q[prow][j] - amt_q[j];
				end
				if (rollback) begin
					free_q[j]        <= free_q[j] + amt_q[j];
					held_q[prow][j]  <= held_q[prow][j] - amt_q[j];
					claim_q[prow][j] <= claim_q[prow][j] + amt_q[j];
				end
			end
			if (scan_init) begin
				for (int j = 0; j < NUM_RES; j++) begin
					work_q[j] <= WORK_BITS'(free_q[j]);
				end
				fin_q      <= '0;
				count_q    <= '0;
				idx_q      <= '0;
				pos_q      <= '0;
				progress_q <= 1'b0;
			end
			if (scan_step) begin
				if (take) begin
					for (int j = 0; j < NUM_RES; j++) begin
						work_q[j] <= work_sum[j];
					end
					fin_q[idx_q] <= 1'b1;
					count_q      <= count_q + 1'b1;
					progress_q   <= 1'b1;
				end
				if (idx_q == LAST_IDX) begin
					idx_q      <= '0;
					progress_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (emit) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (emit) begin
				status_q   <= ST_OK;
				seq_proc_q <= PROC_W'(order_q[pos_q]);
				seq_pos_q  <= PROC_W'(pos_q);
				last_q     <= (pos_q == LAST_IDX);
			end else begin
				status_q   <= res_q;
				seq_proc_q <= '0;
				seq_pos_q  <= '0;
				last_q     <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign seq_process  = seq_proc_q;
	assign seq_position = seq_pos_q;
	assign last         = last_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("Accepted word did not start execution.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_PROCS))
		else $error("Finish count exceeds the process count.");

	a_fin_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> $countones(fin_q) == int'(count_q))
		else $error("Finished flags disagree with the finish count.");

	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> last_q && seq_pos_q == '0)
		else $error("Failure word is not a single last word.");

endmodule
